[design/rar_pkg.sv]
// shared constants and operation codes of the rational arithmetic core
package rar_pkg;

   localparam int DEFAULT_OPERAND_WIDTH = 16;
   localparam int OP_WIDTH = 3;

   localparam logic [OP_WIDTH-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB    = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL    = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV    = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_REDUCE = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_NEGATE = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_RECIP  = 3'd6;

endpackage

[design/rar_if.sv]
// request and response channel interfaces of the rational arithmetic core
interface rar_req_if #(
   parameter int OPERAND_WIDTH = rar_pkg::DEFAULT_OPERAND_WIDTH
);
   import rar_pkg::*;

   logic                            valid;
   logic                            ready;
   logic [OP_WIDTH-1:0]             op;
   logic signed [OPERAND_WIDTH-1:0] a_num;
   logic signed [OPERAND_WIDTH-1:0] a_den;
   logic signed [OPERAND_WIDTH-1:0] b_num;
   logic signed [OPERAND_WIDTH-1:0] b_den;

   modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
   modport sink (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_rsp_if #(
   parameter int OPERAND_WIDTH = rar_pkg::DEFAULT_OPERAND_WIDTH
);
   logic                              valid;
   logic                              ready;
   logic signed [2*OPERAND_WIDTH:0]   res_num;
   logic [2*OPERAND_WIDTH-2:0]        res_den;
   logic                              zero_den_error;

   modport source (output valid, res_num, res_den, zero_den_error, input ready);
   modport sink (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

[design/rational_arith_reduce_core.sv]
// top level of the rational arithmetic core with gcd reduction
// One request at a time: a request is taken only while the core is idle, and the next one is
// not taken until the response has been transferred. The cross products are formed on one
// shared W x W multiplier, the sign is normalised, and for add, sub, mul, div and reduce the
// fraction is reduced with a binary gcd on the 2W-bit magnitudes (common powers of two first,
// then shift or compare-subtract steps on one shared subtractor) followed by two restoring
// divisions on the same subtractor. Negate, reciprocal, a zero numerator and error cases skip
// the reduction. The response holds until it is transferred.
module rational_arith_reduce_core #(
   parameter int OPERAND_WIDTH = rar_pkg::DEFAULT_OPERAND_WIDTH
) (
   input logic        clock,
   input logic        reset,
   rar_req_if.sink    req_ch,
   rar_rsp_if.source  rsp_ch
);
   import rar_pkg::*;

   localparam int W      = OPERAND_WIDTH;
   localparam int NUM_W  = 2 * W + 1;
   localparam int DEN_W  = 2 * W - 1;
   localparam int MAG_W  = 2 * W;
   localparam int PROD_W = 2 * W;
   localparam int SUB_W  = MAG_W + 2;
   localparam int CNT_W  = $clog2(MAG_W);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_N, ST_MUL_D, ST_MUL_X, ST_ACC, ST_SIGN, ST_LOAD,
      ST_TWOS, ST_GCD, ST_DIV_N, ST_DIV_D, ST_RESP
   } state_type;

   state_type                state_ff, state_in;
   logic [OP_WIDTH-1:0]      op_ff, op_in;
   logic signed [W-1:0]      a_num_ff, a_num_in, a_den_ff, a_den_in;
   logic signed [W-1:0]      b_num_ff, b_num_in, b_den_ff, b_den_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [NUM_W-1:0]  n_ff, n_in;
   logic signed [PROD_W-1:0] d_ff, d_in;
   logic                     neg_ff, neg_in;
   logic [MAG_W-1:0]         u_ff, u_in, v_ff, v_in, x_ff, x_in, y_ff, y_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [NUM_W-1:0]  res_num_ff, res_num_in;
   logic [DEN_W-1:0]         res_den_ff, res_den_in;
   logic                     err_ff, err_in;

   // shared multiplier and subtractor
   logic signed [W-1:0]      mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [SUB_W-1:0]         sub_a, sub_b, diff;
   logic                     borrow;
   logic [MAG_W-1:0]         div_src, quo_next, rem_next;
   logic                     div_bit;

   logic                     in_err, is_bin, reduce, is_addsub;
   logic signed [NUM_W-1:0]  n_norm, n_abs;
   logic signed [PROD_W-1:0] d_norm;

   assign mul_p = mul_a * mul_b;

   assign div_src  = (state_ff == ST_DIV_D) ? y_ff : x_ff;
   assign div_bit  = div_src[MAG_W-1];
   assign sub_a    = (state_ff == ST_GCD) ? {2'b00, u_ff} : {1'b0, u_ff, div_bit};
   assign sub_b    = {2'b00, v_ff};
   assign diff     = sub_a - sub_b;
   assign borrow   = diff[SUB_W-1];
   assign quo_next = {div_src[MAG_W-2:0], ~borrow};
   assign rem_next = borrow ? {u_ff[MAG_W-2:0], div_bit} : diff[MAG_W-1:0];

   assign is_bin    = (req_ch.op <= OP_DIV);
   assign in_err    = (req_ch.a_den == '0) || (is_bin && (req_ch.b_den == '0)) ||
                      ((req_ch.op == OP_DIV) && (req_ch.b_num == '0)) ||
                      ((req_ch.op == OP_RECIP) && (req_ch.a_num == '0));
   assign reduce    = !((op_ff == OP_NEGATE) || (op_ff == OP_RECIP));
   assign is_addsub = (op_ff == OP_ADD) || (op_ff == OP_SUB);
   assign n_norm    = d_ff[PROD_W-1] ? -n_ff : n_ff;
   assign d_norm    = d_ff[PROD_W-1] ? -d_ff : d_ff;
   assign n_abs     = n_ff[NUM_W-1] ? -n_ff : n_ff;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      a_num_in   = a_num_ff;
      a_den_in   = a_den_ff;
      b_num_in   = b_num_ff;
      b_den_in   = b_den_ff;
      prod_in    = prod_ff;
      n_in       = n_ff;
      d_in       = d_ff;
      neg_in     = neg_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      cnt_in     = cnt_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      err_in     = err_ff;
      mul_a      = a_den_ff;
      mul_b      = b_num_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.op;
               a_num_in = req_ch.a_num;
               a_den_in = req_ch.a_den;
               b_num_in = req_ch.b_num;
               b_den_in = req_ch.b_den;
               if (in_err) begin
                  res_num_in = '0;
                  res_den_in = '0;
                  err_in     = 1'b1;
                  state_in   = ST_RESP;
               end else begin
                  err_in = 1'b0;
                  if (is_bin) begin
                     state_in = ST_MUL_N;
                  end else begin
                     state_in = ST_SIGN;
                     if (req_ch.op == OP_NEGATE) begin
                        n_in = -NUM_W'(req_ch.a_num);
                        d_in = PROD_W'(req_ch.a_den);
                     end else if (req_ch.op == OP_RECIP) begin
                        n_in = NUM_W'(req_ch.a_den);
                        d_in = PROD_W'(req_ch.a_num);
                     end else begin
                        n_in = NUM_W'(req_ch.a_num);
                        d_in = PROD_W'(req_ch.a_den);
                     end
                  end
               end
            end
         end
         ST_MUL_N: begin
            mul_a    = a_num_ff;
            mul_b    = (op_ff == OP_MUL) ? b_num_ff : b_den_ff;
            prod_in  = mul_p;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            n_in     = NUM_W'(prod_ff);
            mul_a    = a_den_ff;
            mul_b    = (op_ff == OP_DIV) ? b_num_ff : b_den_ff;
            prod_in  = mul_p;
            state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            d_in     = prod_ff;
            mul_a    = a_den_ff;
            mul_b    = b_num_ff;
            prod_in  = mul_p;
            state_in = is_addsub ? ST_ACC : ST_SIGN;
         end
         ST_ACC: begin
            n_in     = (op_ff == OP_SUB) ? n_ff - NUM_W'(prod_ff) : n_ff + NUM_W'(prod_ff);
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            n_in = n_norm;
            d_in = d_norm;
            if (reduce) begin
               state_in = ST_LOAD;
            end else begin
               res_num_in = n_norm;
               res_den_in = d_norm[DEN_W-1:0];
               state_in   = ST_RESP;
            end
         end
         ST_LOAD: begin
            if (n_ff == '0) begin
               res_num_in = '0;
               res_den_in = DEN_W'(1);
               state_in   = ST_RESP;
            end else begin
               neg_in   = n_ff[NUM_W-1];
               u_in     = n_abs[MAG_W-1:0];
               x_in     = n_abs[MAG_W-1:0];
               v_in     = d_ff[MAG_W-1:0];
               y_in     = d_ff[MAG_W-1:0];
               state_in = ST_TWOS;
            end
         end
         ST_TWOS: begin
            // strip common powers of two from the gcd and both operands together
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            priority if (diff == '0) begin
               // odd gcd sits in v and divides the shifted operands
               u_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIV_N;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (borrow) begin
               u_in = v_ff;
               v_in = u_ff;
            end else begin
               u_in = diff[MAG_W-1:0];
            end
         end
         ST_DIV_N: begin
            x_in   = quo_next;
            u_in   = rem_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               u_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIV_D;
            end
         end
         ST_DIV_D: begin
            y_in   = quo_next;
            u_in   = rem_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               res_num_in = neg_ff ? -$signed({1'b0, x_ff}) : $signed({1'b0, x_ff});
               res_den_in = quo_next[DEN_W-1:0];
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff      <= op_in;
      a_num_ff   <= a_num_in;
      a_den_ff   <= a_den_in;
      b_num_ff   <= b_num_in;
      b_den_ff   <= b_den_in;
      prod_ff    <= prod_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      neg_ff     <= neg_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      cnt_ff     <= cnt_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      err_ff     <= err_in;
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = (state_ff == ST_RESP);
   assign rsp_ch.res_num        = res_num_ff;
   assign rsp_ch.res_den        = res_den_ff;
   assign rsp_ch.zero_den_error = err_ff;

endmodule

[design/rar_checker.sv]
// port-level assertions of the rational arithmetic core and their bind
module rar_checker #(
   parameter int OPERAND_WIDTH = rar_pkg::DEFAULT_OPERAND_WIDTH
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [2*OPERAND_WIDTH:0] rsp_res_num,
   input logic [2*OPERAND_WIDTH-2:0]      rsp_res_den,
   input logic                            rsp_zero_den_error
);
   import rar_pkg::*;

   // a waiting response stays up until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // one item in flight: no request taken while a response waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while response pending");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("core still ready after request transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_den_error |-> (rsp_res_num == '0) && (rsp_res_den == '0))
      else $error("error response carries a non-zero fraction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_den_error |-> (rsp_res_den != '0))
      else $error("zero denominator without error flag");

endmodule

bind rational_arith_reduce_core rar_checker #(
   .OPERAND_WIDTH(OPERAND_WIDTH)
) u_rar_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_res_num        (rsp_ch.res_num),
   .rsp_res_den        (rsp_ch.res_den),
   .rsp_zero_den_error (rsp_ch.zero_den_error)
);
